// ----- design/adpt_pkg.sv -----
package adpt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int ADDR_W  = 48;
    localparam int SIG_W   = 8;
    localparam int KIND_W  = 3;
    localparam int RIDX_W  = 6;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int ECNT_W  = 7;

    // event kinds up to this code mark the entry connectable
    localparam logic [KIND_W-1:0] KIND_CONN_MAX = 3'd1;

    typedef enum logic [1:0] {
        ACT_REPORT = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_RANGE    = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]              action;
        logic [ADDR_W-1:0]       address;
        logic signed [SIG_W-1:0] signal;
        logic [KIND_W-1:0]       event_kind;
        logic [RIDX_W-1:0]       read_index;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [SLOT_W-1:0]       slot;
        logic [ADDR_W-1:0]       entry_address;
        logic signed [SIG_W-1:0] peak_signal;
        logic                    is_connectable;
        logic [ECNT_W-1:0]       entry_count;
    } t_result;

    // query word walking the cell row, with the answer it picks up
    typedef struct packed {
        logic [1:0]              action;
        logic [ADDR_W-1:0]       addr;
        logic signed [SIG_W-1:0] sig;
        logic [KIND_W-1:0]       kind;
        logic [RIDX_W-1:0]       ridx;
        logic                    hit;
        logic [STAT_W-1:0]       status;
        logic [SLOT_W-1:0]       slot;
        logic [ADDR_W-1:0]       res_addr;
        logic signed [SIG_W-1:0] res_peak;
        logic                    res_conn;
    } t_token;

endpackage

// ----- design/adpt_cell.sv -----
module adpt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  adpt_pkg::t_token     i_tok,
    input  logic [CNT_W-1:0]     i_count,
    output logic                 o_valid,
    output adpt_pkg::t_token     o_tok
);

    logic [adpt_pkg::ADDR_W-1:0]       r_addr, n_addr;
    logic signed [adpt_pkg::SIG_W-1:0] r_peak, n_peak;
    logic                              r_conn, n_conn;
    logic                              r_valid;
    adpt_pkg::t_token                  r_tok, n_tok;

    logic in_use;
    logic is_conn;
    logic take_sig;

    always_comb begin
        in_use   = CNT_W'(INDEX) < i_count;
        is_conn  = i_tok.kind <= adpt_pkg::KIND_CONN_MAX;
        take_sig = (i_tok.sig > r_peak) || (r_peak == '0);
        n_tok    = i_tok;
        n_addr   = r_addr;
        n_peak   = r_peak;
        n_conn   = r_conn;
        if (i_valid && !i_tok.hit) begin
            if (i_tok.action == adpt_pkg::ACT_REPORT) begin
                if (in_use && r_addr == i_tok.addr) begin
                    n_peak = take_sig ? i_tok.sig : r_peak;
                    n_conn = r_conn | is_conn;
                    n_tok.hit    = 1'b1;
                    n_tok.status = adpt_pkg::ST_UPDATED;
                end else if (CNT_W'(INDEX) == i_count) begin
                    // append: the new entry takes the report's address, signal and connectable mark
                    n_addr = i_tok.addr;
                    n_peak = i_tok.sig;
                    n_conn = is_conn;
                    n_tok.hit    = 1'b1;
                    n_tok.status = adpt_pkg::ST_INSERTED;
                end
            end else if (i_tok.action == adpt_pkg::ACT_READ) begin
                if (in_use && 32'(i_tok.ridx) == INDEX) begin
                    n_tok.hit    = 1'b1;
                    n_tok.status = adpt_pkg::ST_READ_OK;
                end
            end
            if (n_tok.hit) begin
                n_tok.slot     = adpt_pkg::SLOT_W'(INDEX);
                n_tok.res_addr = n_addr;
                n_tok.res_peak = n_peak;
                n_tok.res_conn = n_conn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok  <= n_tok;
        r_addr <= n_addr;
        r_peak <= n_peak;
        r_conn <= n_conn;
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// ----- design/advert_dedup_peak_table_top.sv -----
// Advertiser table: deduplicates radio reports by 48-bit device address and
// keeps the peak signal and a connectable mark for each known device.
// Input: an item word on i_item is taken at a rising edge with start high
// and busy low. Report items look up or append an entry, clear items empty
// the table, read items return the entry at read_index.
// Output: each item but one with an unused action code gives one result
// word on o_result, shown for a single cycle with o_valid high.
// Timing: a report or read walks the row of TABLE_DEPTH cells, one cell
// per cycle; each cell registers the query word and the result is
// registered once more after the last cell. busy is high during the walk
// and low again as the result shows, when a new item can be taken.
// A clear leaves busy low and strobes its result in the cycle after.
// Reset empties the table (entry count zero) and drops any walk in flight;
// entry contents are not cleared and are only read once written.
// The receiver cannot stall: every result must be taken in its cycle.
module advert_dedup_peak_table_top #(
    parameter int TABLE_DEPTH = adpt_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  adpt_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_valid,
    output adpt_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                r_busy, n_busy;
    logic                r_valid, n_valid;
    logic [CNT_W-1:0]    r_count, n_count;
    adpt_pkg::t_result   r_result, n_result;

    logic                vld [0:TABLE_DEPTH];
    adpt_pkg::t_token    tok [0:TABLE_DEPTH];

    logic                accept;
    logic                is_walk;
    logic [31:0]         cnt32;
    adpt_pkg::t_token    last;

    assign accept  = start && !r_busy;
    assign is_walk = (i_item.action == adpt_pkg::ACT_REPORT) ||
                     (i_item.action == adpt_pkg::ACT_READ);

    always_comb begin
        vld[0]          = accept && is_walk;
        tok[0].action   = i_item.action;
        tok[0].addr     = i_item.address;
        tok[0].sig      = i_item.signal;
        tok[0].kind     = i_item.event_kind;
        tok[0].ridx     = i_item.read_index;
        tok[0].hit      = 1'b0;
        tok[0].status   = adpt_pkg::ST_UPDATED;
        tok[0].slot     = '0;
        tok[0].res_addr = '0;
        tok[0].res_peak = '0;
        tok[0].res_conn = 1'b0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        adpt_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .i_tok   (tok[g]),
            .i_count (r_count),
            .o_valid (vld[g+1]),
            .o_tok   (tok[g+1])
        );
    end

    assign last = tok[TABLE_DEPTH];

    always_comb begin
        n_busy   = r_busy;
        n_valid  = 1'b0;
        n_count  = r_count;
        n_result = r_result;
        if (accept) begin
            if (i_item.action == adpt_pkg::ACT_CLEAR) begin
                n_count  = '0;
                n_valid  = 1'b1;
                n_result = '0;
                n_result.status = adpt_pkg::ST_CLEARED;
            end else if (is_walk) begin
                n_busy = 1'b1;
            end
        end
        if (vld[TABLE_DEPTH]) begin
            n_busy   = 1'b0;
            n_valid  = 1'b1;
            n_result = '0;
            if (last.hit) begin
                n_result.status         = last.status;
                n_result.slot           = last.slot;
                n_result.entry_address  = last.res_addr;
                n_result.peak_signal    = last.res_peak;
                n_result.is_connectable = last.res_conn;
                if (last.status == adpt_pkg::ST_INSERTED) begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (last.action == adpt_pkg::ACT_READ) begin
                n_result.status = adpt_pkg::ST_RANGE;
                n_result.slot   = last.ridx;
            end else begin
                // no match and no free cell: drop the report
                n_result.status = adpt_pkg::ST_DROPPED;
            end
        end
        cnt32 = 32'(n_count);
        if (n_valid) begin
            n_result.entry_count = cnt32[adpt_pkg::ECNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- design/adpt_checker.sv -----
module adpt_checker #(
    parameter int DEPTH = adpt_pkg::TABLE_DEPTH_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input adpt_pkg::t_item   i_item,
    input logic              busy,
    input logic              o_valid,
    input adpt_pkg::t_result o_result
);

    localparam logic [31:0] DEPTH32 = 32'(DEPTH);

    logic take_walk;
    logic take_clear;
    logic take_none;

    assign take_walk  = start && !busy &&
                        (i_item.action == adpt_pkg::ACT_REPORT ||
                         i_item.action == adpt_pkg::ACT_READ);
    assign take_clear = start && !busy && i_item.action == adpt_pkg::ACT_CLEAR;
    assign take_none  = start && !busy && !take_walk && !take_clear;

    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_walk |=> busy && !o_valid)
        else $error("walk item not held busy");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_clear |=> o_valid && o_result.status == adpt_pkg::ST_CLEARED &&
                       o_result.entry_count == '0)
        else $error("clear result missing or wrong");

    a_none_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_none |=> !o_valid)
        else $error("unused action produced a result");

    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result strobed while busy");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == adpt_pkg::ST_DROPPED |->
            o_result.entry_count == DEPTH32[adpt_pkg::ECNT_W-1:0])
        else $error("report dropped while table not full");

endmodule

bind advert_dedup_peak_table_top adpt_checker #(
    .DEPTH (TABLE_DEPTH)
) u_adpt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
